### rtl/kmpf_pkg.sv
`timescale 1ns / 1ps
// kmpf_pkg: shared types and constants of the metadata local-set packet framer.
// No dependencies.
package kmpf_pkg;

  localparam int unsigned PktWords = 39;
  localparam int unsigned SumWords = 38;
  localparam int unsigned WordIdxW = 6;
  localparam int unsigned PktBits  = SumWords * 16;

  localparam logic [WordIdxW-1:0] LastWordIdx = WordIdxW'(PktWords - 1);

  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CfgMissionHigh  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgMissionLow   = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgPlatformHigh = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgPlatformLow  = 8'd3;

  localparam logic [127:0] LdsKey = 128'h060E2B34_020B0101_0E010301_01000000;
  localparam logic [7:0]   LdsLen = 8'h3D;

  localparam logic [15:0] PairTime     = 16'h0208;
  localparam logic [15:0] PairMission  = 16'h030C;
  localparam logic [15:0] PairPlatform = 16'h0A0C;
  localparam logic [15:0] PairLat      = 16'h0D04;
  localparam logic [15:0] PairLon      = 16'h0E04;
  localparam logic [15:0] PairAlt      = 16'h0F02;
  localparam logic [15:0] PairVersion  = 16'h4101;
  localparam logic [7:0]  LdsVersion   = 8'h02;
  localparam logic [15:0] PairChecksum = 16'h0102;

  typedef struct packed {
    logic [63:0]        time_us;
    logic signed [31:0] lat_scaled;
    logic signed [31:0] lon_scaled;
    logic [15:0]        alt_scaled;
  } kmpf_req_t;

  typedef struct packed {
    logic [63:0] mission_high;
    logic [31:0] mission_low;
    logic [63:0] platform_high;
    logic [31:0] platform_low;
  } kmpf_cfg_t;

  typedef struct packed {
    logic                out_valid;
    logic [WordIdxW-1:0] word_idx;
  } kmpf_seq_stat_t;

endpackage

### rtl/kmpf_req_queue.sv
`timescale 1ns / 1ps
// kmpf_req_queue: front end, a small request queue between input and word sequencer.
// Depends on kmpf_pkg.
module kmpf_req_queue
  import kmpf_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  kmpf_req_t req_i,
  output logic      full_o,
  output logic      valid_o,
  output kmpf_req_t head_o,
  input  logic      pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  kmpf_req_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= req_i;
    end
  end

endmodule

### rtl/kmpf_word_seq.sv
`timescale 1ns / 1ps
// kmpf_word_seq: back end, steps through the 39 packet words of the head request
// into an output register and accumulates the checksum. Depends on kmpf_pkg.
module kmpf_word_seq
  import kmpf_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  kmpf_req_t      req_i,
  output logic           req_pop_o,
  input  kmpf_cfg_t      cfg_i,
  output logic           out_valid_o,
  output logic [15:0]    out_word_o,
  output logic           out_final_o,
  input  logic           out_pop_i,
  output kmpf_seq_stat_t stat_o
);

  logic [PktBits-1:0]  pkt;
  logic [15:0]         words [SumWords];
  logic [15:0]         word_cur;
  logic                last;
  logic                adv;
  logic [WordIdxW-1:0] widx_q, widx_d;
  logic [15:0]         sum_q, sum_d;
  logic                out_valid_q, out_valid_d;
  logic [15:0]         out_word_q;
  logic                out_final_q;

  assign pkt = {LdsKey, LdsLen,
                PairTime, req_i.time_us,
                PairMission, cfg_i.mission_high, cfg_i.mission_low,
                PairPlatform, cfg_i.platform_high, cfg_i.platform_low,
                PairLat, req_i.lat_scaled,
                PairLon, req_i.lon_scaled,
                PairAlt, req_i.alt_scaled,
                PairVersion, LdsVersion,
                PairChecksum};

  always_comb begin
    for (int i = 0; i < SumWords; i++) begin
      words[i] = pkt[PktBits - 1 - 16 * i -: 16];
    end
  end

  assign last     = (widx_q == LastWordIdx);
  assign word_cur = last ? sum_q : words[widx_q];
  assign adv      = req_valid_i && (!out_valid_q || out_pop_i);
  assign req_pop_o = adv && last;

  always_comb begin
    widx_d      = widx_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
      widx_d      = last ? '0 : widx_q + 1'b1;
      sum_d       = last ? '0 : sum_q + word_cur;
    end else if (out_pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      widx_q      <= widx_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_word_q  <= word_cur;
      out_final_q <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_final_o = out_final_q;
  assign stat_o      = '{out_valid: out_valid_q, word_idx: widx_q};

endmodule

### rtl/klv_metadata_packet_framer_unit.sv
`timescale 1ns / 1ps
// klv_metadata_packet_framer_unit: top level, config registers, request queue and
// word sequencer. Depends on kmpf_pkg, kmpf_req_queue, kmpf_word_seq.
//
//   channel   | handshake              | payload
//   ----------+------------------------+-----------------------------------------
//   request   | push / full            | time_us_i, lat/lon/alt_scaled_i
//   result    | pop / empty            | packet_word_o, final_word_o
//   config    | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// Each request yields 39 words, one per cycle while pop is held; the sequencer
// has a single output word register.
// First word passes through the request queue and then the output word register to the ports.
// The request queue takes further items while a packet is being sent.
// Reset clears queue, sequencer and config registers; no clearing pass.
module klv_metadata_packet_framer_unit
  import kmpf_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [63:0]         time_us_i,
  input  logic signed [31:0]  lat_scaled_i,
  input  logic signed [31:0]  lon_scaled_i,
  input  logic [15:0]         alt_scaled_i,
  output logic                empty,
  input  logic                pop,
  output logic [15:0]         packet_word_o,
  output logic                final_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [63:0]         cfg_data_i
);

  kmpf_cfg_t      cfg_q;
  kmpf_req_t      req_in, req_head;
  logic           q_valid, q_pop;
  logic           out_valid;
  kmpf_seq_stat_t seq_stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgMissionHigh:  cfg_q.mission_high  <= cfg_data_i;
        CfgMissionLow:   cfg_q.mission_low   <= cfg_data_i[31:0];
        CfgPlatformHigh: cfg_q.platform_high <= cfg_data_i;
        CfgPlatformLow:  cfg_q.platform_low  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign req_in = '{time_us: time_us_i, lat_scaled: lat_scaled_i,
                    lon_scaled: lon_scaled_i, alt_scaled: alt_scaled_i};

  kmpf_req_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .req_i  (req_in),
    .full_o (full),
    .valid_o(q_valid),
    .head_o (req_head),
    .pop_i  (q_pop)
  );

  kmpf_word_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(q_valid),
    .req_i      (req_head),
    .req_pop_o  (q_pop),
    .cfg_i      (cfg_q),
    .out_valid_o(out_valid),
    .out_word_o (packet_word_o),
    .out_final_o(final_word_o),
    .out_pop_i  (pop),
    .stat_o     (seq_stat)
  );

  assign empty = !out_valid;

  a_widx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_stat.word_idx <= LastWordIdx)
    else $error("word index past end of packet");

  a_pop_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> (seq_stat.word_idx == '0))
    else $error("request released without restarting word count");

  a_final_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (final_word_o == (seq_stat.word_idx == '0)))
    else $error("final flag out of step with word count");

  a_valid_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_stat.out_valid == !empty)
    else $error("output valid mismatch");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench of klv_metadata_packet_framer_unit. It predicts the
// 39 words of each packet and checks every popped word. Depends on kmpf_pkg and the RTL.
module tb_top;
  import kmpf_pkg::*;

  localparam int unsigned FrameWords = 39;
  localparam int unsigned SummedWords = 38;
  localparam int unsigned MaxGap = 17;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned RandomPhases = 6;
  localparam int unsigned ItemsPerPhase = 35;

  localparam logic [127:0] UniversalKey = 128'h060E2B34_020B0101_0E010301_01000000;
  localparam logic [7:0]   SetLength    = 8'h3D;
  localparam logic [15:0]  TlTime       = 16'h0208;
  localparam logic [15:0]  TlMission    = 16'h030C;
  localparam logic [15:0]  TlPlatform   = 16'h0A0C;
  localparam logic [15:0]  TlLat        = 16'h0D04;
  localparam logic [15:0]  TlLon        = 16'h0E04;
  localparam logic [15:0]  TlAlt        = 16'h0F02;
  localparam logic [15:0]  TlVersion    = 16'h4101;
  localparam logic [7:0]   VersionByte  = 8'h02;
  localparam logic [15:0]  TlChecksum   = 16'h0102;
  localparam logic [CfgIdxW-1:0] FirstUnusedIdx = CfgPlatformLow + 1'b1;

  typedef struct packed {
    logic [15:0] word;
    logic        last;
  } frame_word_t;

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  logic [63:0]         time_us_i;
  logic signed [31:0]  lat_scaled_i;
  logic signed [31:0]  lon_scaled_i;
  logic [15:0]         alt_scaled_i;
  logic                empty;
  logic                pop;
  logic [15:0]         packet_word_o;
  logic                final_word_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [63:0]         cfg_data_i;

  kmpf_cfg_t   text_regs;
  frame_word_t pending_words[$];
  int unsigned error_count;
  int unsigned stall_cycles;
  bit          tx_steady;
  bit          rx_steady;

  klv_metadata_packet_framer_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .time_us_i     (time_us_i),
    .lat_scaled_i  (lat_scaled_i),
    .lon_scaled_i  (lon_scaled_i),
    .alt_scaled_i  (alt_scaled_i),
    .empty         (empty),
    .pop           (pop),
    .packet_word_o (packet_word_o),
    .final_word_o  (final_word_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Builds the packet for one request and queues its words.
  function automatic void frame_packet(input kmpf_req_t req);
    logic [SummedWords*16-1:0] body;
    logic [15:0] sum;
    logic [15:0] w;
    body = {UniversalKey, SetLength,
            TlTime, req.time_us,
            TlMission, text_regs.mission_high, text_regs.mission_low,
            TlPlatform, text_regs.platform_high, text_regs.platform_low,
            TlLat, req.lat_scaled,
            TlLon, req.lon_scaled,
            TlAlt, req.alt_scaled,
            TlVersion, VersionByte,
            TlChecksum};
    sum = '0;
    for (int i = 0; i < SummedWords; i++) begin
      w = body[SummedWords*16-1-16*i -: 16];
      sum = sum + w;
      pending_words.push_back({w, 1'b0});
    end
    pending_words.push_back({sum, 1'b1});
  endfunction

  function automatic int unsigned draw_gap(input bit steady);
    if (steady) return 0;
    return $urandom_range(0, MaxGap);
  endfunction

  function automatic logic [63:0] pick_bits64();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      3: return ~(64'd1 << $urandom_range(0, 63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [CfgIdxW-1:0] pick_unused_idx();
    return CfgIdxW'($urandom_range(FirstUnusedIdx, 255));
  endfunction

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= StallLimit);
    $display("Mismatches found");
    $finish;
  end

  // Result side: random pop stalls, each popped word checked against the oldest one queued.
  initial begin
    int unsigned gap;
    int unsigned word_pos;
    frame_word_t exp_word;
    word_pos = 0;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = draw_gap(rx_steady);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty !== 1'b0);
      if (pending_words.size() == 0) begin
        error_count++;
        $display("%0t: unexpected word expected none actual %h final %b", $time,
                 packet_word_o, final_word_o);
      end else begin
        exp_word = pending_words.pop_front();
        if (packet_word_o !== exp_word.word) begin
          error_count++;
          $display("%0t: word %0d expected %h actual %h", $time, word_pos,
                   exp_word.word, packet_word_o);
        end
        if (final_word_o !== exp_word.last) begin
          error_count++;
          $display("%0t: final flag of word %0d expected %b actual %b", $time, word_pos,
                   exp_word.last, final_word_o);
        end
        word_pos = exp_word.last ? 0 : word_pos + 1;
      end
    end
  end

  // Leaves push high on return; the next call or wait_idle drives it.
  task automatic send_request(input logic [63:0] t_us, input logic [31:0] lat,
                              input logic [31:0] lon, input logic [15:0] alt);
    kmpf_req_t req;
    int unsigned gap;
    req.time_us    = t_us;
    req.lat_scaled = lat;
    req.lon_scaled = lon;
    req.alt_scaled = alt;
    gap = draw_gap(tx_steady);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push         <= 1'b1;
    time_us_i    <= req.time_us;
    lat_scaled_i <= req.lat_scaled;
    lon_scaled_i <= req.lon_scaled;
    alt_scaled_i <= req.alt_scaled;
    do @(posedge clk_i); while (full !== 1'b0);
    frame_packet(req);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high; load_text lowers it after the last write.
  task automatic set_register(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      CfgMissionHigh:  text_regs.mission_high  = data;
      CfgMissionLow:   text_regs.mission_low   = data[31:0];
      CfgPlatformHigh: text_regs.platform_high = data;
      CfgPlatformLow:  text_regs.platform_low  = data[31:0];
      default: ;
    endcase
  endtask

  task automatic load_text(input logic [63:0] mh, input logic [63:0] ml,
                           input logic [63:0] ph, input logic [63:0] pl,
                           input bit with_stray);
    wait_idle();
    if (with_stray) set_register(pick_unused_idx(), pick_bits64());
    set_register(CfgMissionHigh, mh);
    set_register(CfgMissionLow, ml);
    if (with_stray) set_register(pick_unused_idx(), pick_bits64());
    set_register(CfgPlatformHigh, ph);
    set_register(CfgPlatformLow, pl);
    if (with_stray) set_register(pick_unused_idx(), pick_bits64());
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_request('0, '0, '0, '0);
    send_request(64'h0001_0203_0405_0607, 32'h1234_5678, 32'h9ABC_DEF0, 16'h4321);
  endtask

  task automatic test_field_extremes();
    send_request('1, '1, '1, '1);
    send_request(64'h8000_0000_0000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000);
    send_request(64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF);
    send_request(64'h0000_0000_0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 16'h0001);
    send_request(64'hFFFF_FFFF_0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 16'hFFFF);
    send_request(64'h0000_0000_FFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555);
  endtask

  // Printable text, zero bytes, non-ASCII bytes; upper data bits of the short registers set.
  task automatic test_text_bytes();
    load_text(64'h4D49_5353_494F_4E5F, 64'hFFFF_FFFF_3031_4132,
              64'h504C_4154_2D55_4156, 64'h1234_5678_2058_3700, 1'b0);
    send_request(64'h0005_F0E1_D2C3_B4A5, 32'h1C71_C71C, 32'hE38E_38E4, 16'h2F00);
    load_text(64'h00FF_0080_7F00_FF01, 64'h0000_0000_8000_00FF,
              64'hFF00_FF00_0000_0000, 64'hDEAD_BEEF_0000_0000, 1'b0);
    send_request(64'h0000_0000_0000_0000, 32'hC000_0000, 32'h4000_0000, 16'hFF00);
  endtask

  task automatic test_ignored_index();
    wait_idle();
    set_register(FirstUnusedIdx, '1);
    set_register(8'hFF, '1);
    set_register(8'h80, 64'h0123_4567_89AB_CDEF);
    cfg_valid_i <= 1'b0;
    send_request(64'h0102_0304_0506_0708, 32'h0A0B_0C0D, 32'h0E0F_1011, 16'h1213);
  endtask

  // Large words everywhere, so the sum wraps several times.
  task automatic test_checksum_carry();
    load_text('1, '1, '1, '1, 1'b0);
    send_request('1, '1, '1, '1);
    send_request('1, 32'hFFFF_FFFE, '1, 16'hFFFE);
  endtask

  task automatic test_random_packets();
    logic [63:0] t_us;
    logic [63:0] lat;
    logic [63:0] lon;
    logic [63:0] alt;
    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0: load_text('0, '0, '0, '0, 1'b1);
        1: load_text('1, '1, '1, '1, 1'b1);
        default: load_text(pick_bits64(), pick_bits64(), pick_bits64(), pick_bits64(), 1'b1);
      endcase
      tx_steady = (p == 2) || (p == 4);
      rx_steady = (p == 3) || (p == 4);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        t_us = pick_bits64();
        lat  = pick_bits64();
        lon  = pick_bits64();
        alt  = pick_bits64();
        send_request(t_us, lat[31:0], lon[63:32], alt[15:0]);
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    error_count = 0;
    stall_cycles = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    text_regs = '0;
    push         <= 1'b0;
    time_us_i    <= '0;
    lat_scaled_i <= '0;
    lon_scaled_i <= '0;
    alt_scaled_i <= '0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= '0;
    cfg_data_i   <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_field_extremes();
    test_text_bytes();
    test_ignored_index();
    test_checksum_carry();
    test_random_packets();

    wait_idle();
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
